// File: sv/afp_pkg.sv
package afp_pkg;

  localparam int unsigned CHANNELS = 8;

  localparam logic [7:0] ChMask = 8'((1 << CHANNELS) - 1);

  localparam logic [7:0] FrameLimitReset = 8'd79;

  localparam logic [7:0] ChrStart  = 8'h24; // '$'
  localparam logic [7:0] ChrHeader = 8'h44; // 'D'
  localparam logic [7:0] ChrTokenX = 8'h78; // 'x'
  localparam logic [7:0] ChrColon  = 8'h3a; // ':'
  localparam logic [7:0] ChrEnd    = 8'h23; // '#'
  localparam logic [7:0] ChrZero   = 8'h30; // '0'
  localparam logic [7:0] ChrOne    = 8'h31; // '1'
  localparam logic [7:0] ChrLastCh = 8'(32'h31 + CHANNELS - 1);

  typedef enum logic [1:0] {
    EV_NONE   = 2'd0,
    EV_ACCEPT = 2'd1,
    EV_REJECT = 2'd2,
    EV_ABORT  = 2'd3
  } event_e;

  typedef enum logic [3:0] {
    PH_IDLE  = 4'b0001,
    PH_X     = 4'b0010,
    PH_DIGIT = 4'b0100,
    PH_COLON = 4'b1000
  } phase_e;

  typedef struct packed {
    event_e      event_code;
    logic [7:0]  sensor_bits;
    logic        has_valid;
    logic [31:0] frames_accepted;
  } result_t;

endpackage

// File: sv/ascii_sensor_frame_parser_unit.sv
// channel | handshake                   | payload
// --------+-----------------------------+------------------------------------------
// in      | in_valid_i / in_stall_o     | rx_byte_i
// out     | out_valid_o / out_stall_i   | event_code_o, sensor_bits_o, has_valid_o,
//         |                             | frames_accepted_o
// cfg     | frame_limit_we_i            | frame_limit_i
//
// one item per cycle while in_stall_o is low. The frame state updates in the cycle
// the item is accepted; so does the output register unless the output is stalled.
// a skid register takes one result while the output is stalled; in_stall_o is high
// only while the skid register is full, so the input keeps flowing through one stall.
// reset clears all state, sets the committed bits to all ones and the limit to 79.
module ascii_sensor_frame_parser_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        frame_limit_we_i,
  input  logic [7:0]  frame_limit_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  event_code_o,
  output logic [7:0]  sensor_bits_o,
  output logic        has_valid_o,
  output logic [31:0] frames_accepted_o
);
  import afp_pkg::*;

  logic [7:0]  frame_limit_q;
  logic        in_frame_q, in_frame_d;
  logic [7:0]  byte_count_q, byte_count_d;
  logic        header_bad_q, header_bad_d;
  phase_e      phase_q, phase_d;
  logic [2:0]  pending_q, pending_d;
  logic [7:0]  seen_q, seen_d;
  logic [7:0]  staged_q, staged_d;
  logic [7:0]  committed_q, committed_d;
  logic        valid_seen_q, valid_seen_d;
  logic [31:0] accept_cnt_q, accept_cnt_d;
  event_e      event_d;

  result_t     out_q, skid_q, res_d;
  logic        out_valid_q, skid_valid_q;
  logic        in_accept, out_take;
  logic [7:0]  ch_bit;
  logic        is_x;

  assign in_accept = in_valid_i && !skid_valid_q;
  assign out_take  = out_valid_q && !out_stall_i;
  assign ch_bit    = 8'(1) << pending_q;
  assign is_x      = (rx_byte_i == ChrTokenX);

  always_comb begin
    in_frame_d   = in_frame_q;
    byte_count_d = byte_count_q;
    header_bad_d = header_bad_q;
    phase_d      = phase_q;
    pending_d    = pending_q;
    seen_d       = seen_q;
    staged_d     = staged_q;
    committed_d  = committed_q;
    valid_seen_d = valid_seen_q;
    accept_cnt_d = accept_cnt_q;
    event_d      = EV_NONE;

    if (rx_byte_i == ChrStart) begin
      in_frame_d   = 1'b1;
      byte_count_d = 8'd1;
      header_bad_d = 1'b0;
      phase_d      = PH_IDLE;
      pending_d    = '0;
      seen_d       = '0;
      staged_d     = '0;
    end else if (in_frame_q) begin
      if (byte_count_q >= frame_limit_q) begin
        in_frame_d   = 1'b0;
        byte_count_d = '0;
        phase_d      = PH_IDLE;
        event_d      = EV_ABORT;
      end else begin
        if ((byte_count_q == 8'd1 && rx_byte_i != ChrHeader) || rx_byte_i == 8'd0) begin
          header_bad_d = 1'b1;
        end
        byte_count_d = byte_count_q + 8'd1;
        if (rx_byte_i == ChrEnd) begin
          in_frame_d = 1'b0;
          phase_d    = PH_IDLE;
          if (!header_bad_d && (seen_q & ChMask) == ChMask) begin
            committed_d  = (committed_q & ~ChMask) | (staged_q & ChMask);
            valid_seen_d = 1'b1;
            accept_cnt_d = accept_cnt_q + 32'd1;
            event_d      = EV_ACCEPT;
          end else begin
            event_d = EV_REJECT;
          end
        end else begin
          // a failing byte is tried again as the start of a token
          phase_d = is_x ? PH_X : PH_IDLE;
          case (phase_q)
            PH_X: begin
              if (rx_byte_i inside {[ChrOne:ChrLastCh]}) begin
                pending_d = 3'(rx_byte_i - ChrOne);
                phase_d   = PH_DIGIT;
              end
            end
            PH_DIGIT: begin
              if (rx_byte_i == ChrColon) begin
                phase_d = PH_COLON;
              end
            end
            PH_COLON: begin
              if (rx_byte_i inside {ChrZero, ChrOne}) begin
                seen_d   = seen_q | ch_bit;
                staged_d = (rx_byte_i == ChrOne) ? (staged_q | ch_bit) : (staged_q & ~ch_bit);
                phase_d  = PH_IDLE;
              end
            end
            default: ;
          endcase
        end
      end
    end

    res_d.event_code      = event_d;
    res_d.sensor_bits     = committed_d;
    res_d.has_valid       = valid_seen_d;
    res_d.frames_accepted = accept_cnt_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_limit_q <= FrameLimitReset;
      in_frame_q    <= 1'b0;
      byte_count_q  <= '0;
      header_bad_q  <= 1'b0;
      phase_q       <= PH_IDLE;
      pending_q     <= '0;
      seen_q        <= '0;
      staged_q      <= '0;
      committed_q   <= 8'hff;
      valid_seen_q  <= 1'b0;
      accept_cnt_q  <= '0;
    end else begin
      if (frame_limit_we_i) begin
        frame_limit_q <= frame_limit_i;
      end
      if (in_accept) begin
        in_frame_q   <= in_frame_d;
        byte_count_q <= byte_count_d;
        header_bad_q <= header_bad_d;
        phase_q      <= phase_d;
        pending_q    <= pending_d;
        seen_q       <= seen_d;
        staged_q     <= staged_d;
        committed_q  <= committed_d;
        valid_seen_q <= valid_seen_d;
        accept_cnt_q <= accept_cnt_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (skid_valid_q) begin
        if (out_take) begin
          skid_valid_q <= 1'b0;
        end
      end else if (in_accept) begin
        if (out_valid_q && !out_take) begin
          skid_valid_q <= 1'b1;
        end else begin
          out_valid_q <= 1'b1;
        end
      end else if (out_take) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_take) begin
        out_q <= skid_q;
      end
    end else if (in_accept) begin
      if (out_valid_q && !out_take) begin
        skid_q <= res_d;
      end else begin
        out_q <= res_d;
      end
    end
  end

  assign in_stall_o        = skid_valid_q;
  assign out_valid_o       = out_valid_q;
  assign event_code_o      = out_q.event_code;
  assign sensor_bits_o     = out_q.sensor_bits;
  assign has_valid_o       = out_q.has_valid;
  assign frames_accepted_o = out_q.frames_accepted;

endmodule

// File: tb/tb_ascii_sensor_frame_parser_unit.sv
`timescale 1ns / 100ps

module tb_ascii_sensor_frame_parser_unit;
  import afp_pkg::*;

  localparam int unsigned CycleLimit = 200_000;
  localparam int unsigned RandItems  = 400;
  localparam int unsigned NumPhases  = 6;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        frame_limit_we_i = 1'b0;
  logic [7:0]  frame_limit_i = 8'd0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [7:0]  rx_byte_i = 8'd0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [1:0]  event_code_o;
  logic [7:0]  sensor_bits_o;
  logic        has_valid_o;
  logic [31:0] frames_accepted_o;

  ascii_sensor_frame_parser_unit u_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .frame_limit_we_i  (frame_limit_we_i),
    .frame_limit_i     (frame_limit_i),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .rx_byte_i         (rx_byte_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .event_code_o      (event_code_o),
    .sensor_bits_o     (sensor_bits_o),
    .has_valid_o       (has_valid_o),
    .frames_accepted_o (frames_accepted_o)
  );

  always #2 clk_i = ~clk_i;

  // frame parser shadow state
  logic [7:0]  p_limit = FrameLimitReset;
  logic        p_in_frame = 1'b0;
  logic [7:0]  p_count = 8'd0;
  logic        p_hdr_bad = 1'b0;
  phase_e      p_phase = PH_IDLE;
  logic [2:0]  p_chan = 3'd0;
  logic [7:0]  p_seen = 8'd0;
  logic [7:0]  p_staged = 8'd0;
  logic [7:0]  p_committed = 8'hFF;
  logic        p_valid = 1'b0;
  logic [31:0] p_accepts = 32'd0;

  result_t     pending_results[$];
  result_t     oldest;
  logic [7:0]  frame_q[$];

  typedef struct {
    bit         is_cfg;
    logic [7:0] val;
    bit         chk;
    event_e     ev;
  } dir_row_t;
  dir_row_t    dir_rows[$];

  int unsigned errors = 0;
  int unsigned cycles = 0;
  int unsigned bytes_sent = 0;
  int unsigned live_items = 0;
  int unsigned n_acc = 0;
  int unsigned n_rej = 0;
  int unsigned n_abt = 0;
  int unsigned hold_len = 0;
  bit          tx_idle = 1'b1;
  bit          rx_idle = 1'b1;

  function automatic result_t parse_byte(input logic [7:0] b);
    result_t    r;
    logic [7:0] chbit;
    bit         took;
    r.event_code = EV_NONE;
    took = 1'b0;
    if (b == ChrStart) begin
      p_in_frame = 1'b1;
      p_count = 8'd1;
      p_hdr_bad = 1'b0;
      p_phase = PH_IDLE;
      p_chan = 3'd0;
      p_seen = 8'd0;
      p_staged = 8'd0;
    end else if (p_in_frame) begin
      if (p_count >= p_limit) begin
        p_in_frame = 1'b0;
        p_count = 8'd0;
        p_phase = PH_IDLE;
        r.event_code = EV_ABORT;
      end else begin
        if ((p_count == 8'd1 && b != ChrHeader) || b == 8'h00) p_hdr_bad = 1'b1;
        p_count = p_count + 8'd1;
        if (b == ChrEnd) begin
          p_in_frame = 1'b0;
          p_phase = PH_IDLE;
          if (!p_hdr_bad && (p_seen & ChMask) == ChMask) begin
            p_committed = (p_committed & ~ChMask) | (p_staged & ChMask);
            p_valid = 1'b1;
            p_accepts = p_accepts + 32'd1;
            r.event_code = EV_ACCEPT;
          end else begin
            r.event_code = EV_REJECT;
          end
        end else begin
          case (p_phase)
            PH_X: begin
              if (b >= ChrOne && b <= ChrLastCh) begin
                p_chan = 3'(b - ChrOne);
                p_phase = PH_DIGIT;
                took = 1'b1;
              end
            end
            PH_DIGIT: begin
              if (b == ChrColon) begin
                p_phase = PH_COLON;
                took = 1'b1;
              end
            end
            PH_COLON: begin
              if (b == ChrZero || b == ChrOne) begin
                chbit = 8'd1 << p_chan;
                p_seen = p_seen | chbit;
                p_staged = (b == ChrOne) ? (p_staged | chbit) : (p_staged & ~chbit);
                p_phase = PH_IDLE;
                took = 1'b1;
              end
            end
            default: ;
          endcase
          // a byte that breaks a token may itself open the next one
          if (!took) p_phase = (b == ChrTokenX) ? PH_X : PH_IDLE;
        end
      end
    end
    r.sensor_bits = p_committed;
    r.has_valid = p_valid;
    r.frames_accepted = p_accepts;
    return r;
  endfunction

  function automatic void plan(input bit is_cfg, input logic [7:0] v, input bit chk,
                               input event_e ev);
    dir_row_t row;
    row.is_cfg = is_cfg;
    row.val = v;
    row.chk = chk;
    row.ev = ev;
    dir_rows.push_back(row);
  endfunction

  function automatic void add_token(input int unsigned ch, input bit v);
    frame_q.push_back(ChrTokenX);
    frame_q.push_back(8'(ChrOne + ch));
    frame_q.push_back(ChrColon);
    frame_q.push_back(v ? ChrOne : ChrZero);
  endfunction

  task automatic send_byte(input logic [7:0] b, input bit chk, input event_e ev);
    result_t r;
    @(negedge clk_i);
    if (tx_idle && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    rx_byte_i <= b;
    do @(posedge clk_i); while (in_stall_o);
    bytes_sent++;
    if (p_in_frame || b == ChrStart) live_items++;
    r = parse_byte(b);
    // outcome typed in by hand: nothing committed yet in the directed part
    if (chk) begin
      r.event_code = ev;
      r.sensor_bits = 8'hFF;
      r.has_valid = 1'b0;
      r.frames_accepted = 32'd0;
    end
    pending_results.push_back(r);
  endtask

  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_limit(input logic [7:0] v);
    drain();
    @(negedge clk_i);
    frame_limit_we_i <= 1'b1;
    frame_limit_i <= v;
    @(negedge clk_i);
    frame_limit_we_i <= 1'b0;
    p_limit = v;
  endtask

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  // receiver side: random stall bursts plus one long hold-off on request
  initial begin : receiver
    forever begin
      @(negedge clk_i);
      if (hold_len != 0) begin
        out_stall_i <= 1'b1;
        repeat (hold_len) @(negedge clk_i);
        hold_len = 0;
        out_stall_i <= 1'b0;
      end else if (rx_idle && $urandom_range(0, 5) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 19)) @(negedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        $error("result item with nothing expected: event_code %0d", event_code_o);
        errors++;
      end else begin
        oldest = pending_results.pop_front();
        case (oldest.event_code)
          EV_ACCEPT: n_acc++;
          EV_REJECT: n_rej++;
          EV_ABORT:  n_abt++;
          default: ;
        endcase
        if (event_code_o !== oldest.event_code) begin
          $error("event_code: expected %0d, got %0d", oldest.event_code, event_code_o);
          errors++;
        end
        if (sensor_bits_o !== oldest.sensor_bits) begin
          $error("sensor_bits: expected %h, got %h", oldest.sensor_bits, sensor_bits_o);
          errors++;
        end
        if (has_valid_o !== oldest.has_valid) begin
          $error("has_valid: expected %0d, got %0d", oldest.has_valid, has_valid_o);
          errors++;
        end
        if (frames_accepted_o !== oldest.frames_accepted) begin
          $error("frames_accepted: expected %0d, got %0d", oldest.frames_accepted,
                 frames_accepted_o);
          errors++;
        end
      end
    end
  end

  initial begin : stimulus
    int unsigned order[8];
    int unsigned k, sw, tmp, m, skip, base, start_items;
    logic [7:0]  rb;
    logic [7:0]  limits[NumPhases];

    limits = '{8'd255, 8'd2, 8'($urandom_range(16, 40)), 8'd79, 8'd36,
               8'($urandom_range(2, 255))};

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // bytes outside a frame are dropped
    plan(0, 8'h00, 1, EV_NONE);
    plan(0, 8'hFF, 1, EV_NONE);
    plan(0, ChrEnd, 1, EV_NONE);
    // empty frame fails the header check
    plan(0, ChrStart, 1, EV_NONE);
    plan(0, ChrEnd, 1, EV_REJECT);
    // zero byte inside a frame
    plan(0, ChrStart, 1, EV_NONE);
    plan(0, ChrHeader, 1, EV_NONE);
    plan(0, 8'h00, 1, EV_NONE);
    plan(0, ChrEnd, 1, EV_REJECT);
    // wrong header, restart mid-frame, doubled token start
    plan(0, ChrStart, 0, EV_NONE);
    plan(0, 8'h51, 0, EV_NONE);
    plan(0, ChrStart, 0, EV_NONE);
    plan(0, ChrHeader, 0, EV_NONE);
    plan(0, ChrTokenX, 0, EV_NONE);
    plan(0, ChrTokenX, 0, EV_NONE);
    plan(0, ChrOne, 0, EV_NONE);
    plan(0, ChrColon, 0, EV_NONE);
    plan(0, ChrZero, 0, EV_NONE);
    plan(0, ChrEnd, 1, EV_REJECT);
    // end marker arriving at the limit aborts
    plan(1, 8'd2, 0, EV_NONE);
    plan(0, ChrStart, 1, EV_NONE);
    plan(0, ChrHeader, 1, EV_NONE);
    plan(0, ChrEnd, 1, EV_ABORT);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_cfg) write_limit(dir_rows[i].val);
      else send_byte(dir_rows[i].val, dir_rows[i].chk, dir_rows[i].ev);
    end

    for (int ph = 0; ph < NumPhases; ph++) begin
      write_limit(limits[ph]);
      tx_idle = (ph != 3 && ph != NumPhases - 1);
      rx_idle = tx_idle;
      if (ph == 0) hold_len = 300;
      start_items = bytes_sent;
      while (bytes_sent - start_items < RandItems / NumPhases) begin
        frame_q.delete();
        repeat ($urandom_range(0, 2)) frame_q.push_back(8'($urandom_range(0, 255)));
        base = frame_q.size();
        frame_q.push_back(ChrStart);
        frame_q.push_back(ChrHeader);
        m = $urandom_range(0, 15);
        skip = (m == 0) ? $urandom_range(0, 7) : 8;
        for (k = 0; k < 8; k++) order[k] = k;
        for (k = 7; k > 0; k--) begin
          sw = $urandom_range(0, k);
          tmp = order[k];
          order[k] = order[sw];
          order[sw] = tmp;
        end
        for (k = 0; k < 8; k++) begin
          if (order[k] != skip) begin
            // printable filler, never a start or end marker
            if ($urandom_range(0, 3) == 0) frame_q.push_back(8'($urandom_range(8'h25, 8'h7e)));
            add_token(order[k], 1'($urandom_range(0, 1)));
            if ($urandom_range(0, 5) == 0) add_token(order[k], 1'($urandom_range(0, 1)));
          end
        end
        case (m)
          1: frame_q.insert($urandom_range(base + 1, frame_q.size() - 1), 8'h00);
          2: begin
            rb = 8'($urandom_range(0, 255));
            frame_q[base + 1] = (rb == ChrHeader) ? 8'h64 : rb;
          end
          3: begin
            repeat ($urandom_range(1, 5))
              frame_q.insert($urandom_range(base + 1, frame_q.size() - 1),
                             8'($urandom_range(0, 255)));
          end
          4: frame_q.insert($urandom_range(base + 1, frame_q.size() - 1), ChrStart);
          default: ;
        endcase
        // unterminated frame: the next start marker drops it
        if (m != 5) frame_q.push_back(ChrEnd);
        foreach (frame_q[j]) send_byte(frame_q[j], 0, EV_NONE);
        if ($urandom_range(0, 9) == 0) drain();
      end
    end

    drain();
    repeat (8) @(posedge clk_i);

    $display("%0d bytes driven, %0d inside frames; %0d frames accepted, %0d rejected,",
             bytes_sent, live_items, n_acc, n_rej);
    $display("%0d aborted; frame limit swept over %0d settings from 2 to 255, with a long",
             n_abt, NumPhases + 1);
    $display("output hold-off");
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// File: filelist.f
sv/afp_pkg.sv
sv/ascii_sensor_frame_parser_unit.sv
tb/tb_ascii_sensor_frame_parser_unit.sv
